### sv/avgd_pkg.sv
// ----------------------------------------------------------------------------
// avgd_pkg
// Shared types and constants of the adaptive voxel grid downsampler.
// ----------------------------------------------------------------------------
package avgd_pkg;

  localparam int COORD_BITS      = 24;
  localparam int SUM_W           = 56;
  localparam int ISUM_W          = 48;
  localparam int CNT_W           = 32;
  localparam int INT_W           = 16;
  localparam int SLOT_W          = 12;
  localparam int OCC_W           = 13;
  localparam int LVL_W           = 5;
  localparam int BASE_W          = 16;
  localparam int MAXC_W          = 12;
  localparam int OP_W            = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;
  localparam int TABLE_CELLS_DEF = 4096;

  localparam logic [LVL_W-1:0]     MAX_LEVEL      = 5'd31;
  localparam logic [BASE_W-1:0]    BASE_VOXEL_RST = 16'd100;
  localparam logic [MAXC_W-1:0]    MAX_CELLS_RST  = 12'd4000;

  localparam logic [OP_W-1:0]      OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0]      OP_READ  = 2'd1;
  localparam logic [OP_W-1:0]      OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_VOXEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CELLS  = 1'd1;

  typedef struct packed {
    logic        [OP_W-1:0]       op;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic        [INT_W-1:0]      intensity;
    logic        [SLOT_W-1:0]     slot;
  } avgd_in_t;

  typedef struct packed {
    logic        [OCC_W-1:0]      occupied;
    logic        [LVL_W-1:0]      level;
    logic                         cell_valid;
    logic signed [COORD_BITS-1:0] mean_x;
    logic signed [COORD_BITS-1:0] mean_y;
    logic signed [COORD_BITS-1:0] mean_z;
    logic        [INT_W-1:0]      mean_intensity;
  } avgd_out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] key_x;
    logic signed [COORD_BITS-1:0] key_y;
    logic signed [COORD_BITS-1:0] key_z;
    logic signed [SUM_W-1:0]      sum_x;
    logic signed [SUM_W-1:0]      sum_y;
    logic signed [SUM_W-1:0]      sum_z;
    logic        [ISUM_W-1:0]     sum_i;
    logic        [CNT_W-1:0]      cnt;
  } avgd_entry_t;

endpackage

### sv/avgd_div.sv
// ----------------------------------------------------------------------------
// avgd_div
// Shared floor divider: signed dividend over unsigned nonzero divisor, one
// quotient bit per cycle, then a sign fix step.
// ----------------------------------------------------------------------------
module avgd_div #(
  parameter int DW = avgd_pkg::SUM_W,
  parameter int NW = avgd_pkg::CNT_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic signed [DW-1:0] dividend,
  input  logic        [NW-1:0] divisor,
  output logic                 done,
  output logic signed [DW-1:0] quotient
);
  import avgd_pkg::*;

  localparam int CTW = $clog2(DW);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

  dstate_t          st_r;
  logic [CTW-1:0]   cnt_r;
  logic [DW-1:0]    dvd_r;
  logic [DW-1:0]    quo_r;
  logic [NW-1:0]    rem_r;
  logic [NW-1:0]    dsr_r;
  logic             neg_r;
  logic             done_r;
  logic [DW-1:0]    q_r;
  logic [NW:0]      trial;
  logic             fit;

  assign trial    = {rem_r, dvd_r[DW-1]};
  assign fit      = trial >= {1'b0, dsr_r};
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (st_r)
        D_IDLE: begin
          if (go) begin
            neg_r <= dividend[DW-1];
            dvd_r <= dividend[DW-1] ? (~dividend + 1'b1) : dividend;
            dsr_r <= divisor;
            rem_r <= '0;
            quo_r <= '0;
            cnt_r <= CTW'(DW - 1);
            st_r  <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= fit ? NW'(trial - {1'b0, dsr_r}) : NW'(trial);
          quo_r <= {quo_r[DW-2:0], fit};
          dvd_r <= {dvd_r[DW-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            st_r <= D_FIX;
          end
        end
        D_FIX: begin
          if (!neg_r) begin
            q_r <= quo_r;
          end else if (rem_r != '0) begin
            q_r <= ~quo_r;
          end else begin
            q_r <= ~quo_r + 1'b1;
          end
          done_r <= 1'b1;
          st_r   <= D_IDLE;
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

endmodule

### sv/avgd_tbl.sv
// ----------------------------------------------------------------------------
// avgd_tbl
// Cell table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module avgd_tbl #(
  parameter int DEPTH = avgd_pkg::TABLE_CELLS_DEF
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [$clog2(DEPTH)-1:0]    rd_addr,
  output avgd_pkg::avgd_entry_t       rd_data,
  input  logic                        wr_en,
  input  logic [$clog2(DEPTH)-1:0]    wr_addr,
  input  avgd_pkg::avgd_entry_t       wr_data
);
  import avgd_pkg::*;

  avgd_entry_t mem [DEPTH];
  avgd_entry_t rd_r;

  assign rd_data = rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

endmodule

### sv/adaptive_voxel_grid_downsampler.sv
// ----------------------------------------------------------------------------
// adaptive_voxel_grid_downsampler
// Voxel grid accumulator with adaptive coarsening over a cell table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result is
// strobed on out_valid for one cycle, and the receiver cannot stall it. All
// divisions run through one shared floor divider (quotient bits, then sign
// fix), and the table is searched one slot at a time, each slot read and then
// compared. An add costs 3 divisions plus a search of the occupied cells. A
// read of an occupied slot costs 4 divisions; a clear, an unknown op or any
// other read returns its result the cycle after it is taken and never raises
// busy. Each coarsening step re-keys every cell with 6 divisions plus a
// search of the cells packed so far. Occupied slots are always the lowest
// ones, so the fill count marks them and no clearing pass runs after reset.
module adaptive_voxel_grid_downsampler #(
  parameter int TABLE_CELLS = avgd_pkg::TABLE_CELLS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  avgd_pkg::avgd_in_t                   in_data,
  output logic                                 out_valid,
  output avgd_pkg::avgd_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [avgd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [avgd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import avgd_pkg::*;

  localparam int AW = $clog2(TABLE_CELLS);
  localparam int CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_GO, S_DIV_WT, S_SR_RD, S_SR_CMP, S_UPD,
    S_CHECK, S_RK_RD, S_RK_LD, S_RD_LD
  } state_t;

  typedef enum logic [1:0] {K_ADD, K_RK, K_RD} kind_t;

  state_t                      state_r, state_nxt;
  kind_t                       kind_r, kind_nxt;
  logic [2:0]                  step_r, step_nxt;
  logic [BASE_W-1:0]           base_r, base_nxt;
  logic [MAXC_W-1:0]           maxc_r, maxc_nxt;
  logic [CW-1:0]               occ_r, occ_nxt;
  logic [LVL_W-1:0]            lvl_r, lvl_nxt;
  logic [CW-1:0]               n_r, n_nxt;
  logic [CW-1:0]               nold_r, nold_nxt;
  logic [CW-1:0]               src_r, src_nxt;
  logic [CW-1:0]               j_r, j_nxt;
  logic                        hit_r, hit_nxt;
  avgd_entry_t                 cur_r, cur_nxt;
  logic signed [COORD_BITS-1:0] key_r [3];
  logic signed [COORD_BITS-1:0] key_nxt [3];
  logic signed [COORD_BITS-1:0] cent_r, cent_nxt;
  logic                        out_valid_r, out_valid_nxt;
  avgd_out_t                   out_r, out_nxt;

  logic                        div_go;
  logic                        div_done;
  logic signed [SUM_W-1:0]     div_q;
  logic signed [SUM_W-1:0]     div_dvd;
  logic [CNT_W-1:0]            div_dsr;
  logic [CNT_W-1:0]            b32;
  logic [1:0]                  axis;
  logic signed [COORD_BITS-1:0] shifted;

  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  avgd_entry_t                 rd_data;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  avgd_entry_t                 wr_data;
  avgd_entry_t                 inc;
  avgd_entry_t                 merged;
  logic [CNT_W:0]              cnt_sum;
  logic [31:0]                 lim32;
  logic                        fin;
  logic                        fin_valid;

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign b32     = (base_r == '0) ? CNT_W'(1) : CNT_W'(base_r);
  assign lim32   = (32'(maxc_r) > 32'(TABLE_CELLS - 1)) ? 32'(TABLE_CELLS - 1)
                                                         : 32'(maxc_r);
  assign shifted = $signed(div_q[COORD_BITS-1:0]) >>> lvl_r;

  always_comb begin
    inc       = cur_r;
    inc.key_x = key_r[0];
    inc.key_y = key_r[1];
    inc.key_z = key_r[2];
    merged       = rd_data;
    merged.sum_x = rd_data.sum_x + cur_r.sum_x;
    merged.sum_y = rd_data.sum_y + cur_r.sum_y;
    merged.sum_z = rd_data.sum_z + cur_r.sum_z;
    merged.sum_i = rd_data.sum_i + cur_r.sum_i;
    merged.cnt   = rd_data.cnt + cur_r.cnt;
    cnt_sum      = {1'b0, rd_data.cnt} + {1'b0, cur_r.cnt};
  end

  always_comb begin
    axis    = (kind_r == K_RK) ? step_r[2:1] : step_r[1:0];
    div_dsr = cur_r.cnt;
    case (axis)
      2'd0:    div_dvd = cur_r.sum_x;
      2'd1:    div_dvd = cur_r.sum_y;
      2'd2:    div_dvd = cur_r.sum_z;
      default: div_dvd = SUM_W'(cur_r.sum_i);
    endcase
    if (kind_r == K_ADD) begin
      div_dsr = b32;
    end else if (kind_r == K_RK && step_r[0]) begin
      div_dvd = SUM_W'(cent_r);
      div_dsr = b32;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    step_nxt      = step_r;
    base_nxt      = base_r;
    maxc_nxt      = maxc_r;
    occ_nxt       = occ_r;
    lvl_nxt       = lvl_r;
    n_nxt         = n_r;
    nold_nxt      = nold_r;
    src_nxt       = src_r;
    j_nxt         = j_r;
    hit_nxt       = hit_r;
    cur_nxt       = cur_r;
    key_nxt       = key_r;
    cent_nxt      = cent_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    div_go        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = inc;
    fin           = 1'b0;
    fin_valid     = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_BASE_VOXEL: base_nxt = cfg_data[BASE_W-1:0];
        CFG_MAX_CELLS:  maxc_nxt = cfg_data[MAXC_W-1:0];
        default:        ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.op)
            OP_ADD: begin
              cur_nxt.sum_x = SUM_W'(in_data.px);
              cur_nxt.sum_y = SUM_W'(in_data.py);
              cur_nxt.sum_z = SUM_W'(in_data.pz);
              cur_nxt.sum_i = ISUM_W'(in_data.intensity);
              cur_nxt.cnt   = CNT_W'(1);
              kind_nxt      = K_ADD;
              step_nxt      = '0;
              n_nxt         = occ_r;
              state_nxt     = S_DIV_GO;
            end
            OP_READ: begin
              if (32'(in_data.slot) < 32'(TABLE_CELLS) &&
                  32'(in_data.slot) < 32'(occ_r)) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_data.slot);
                kind_nxt  = K_RD;
                step_nxt  = '0;
                state_nxt = S_RD_LD;
              end else begin
                fin = 1'b1;
              end
            end
            OP_CLEAR: begin
              occ_nxt = '0;
              lvl_nxt = '0;
              fin     = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_RD_LD: begin
        cur_nxt   = rd_data;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_go    = 1'b1;
        state_nxt = S_DIV_WT;
      end
      S_DIV_WT: begin
        if (div_done) begin
          state_nxt = S_DIV_GO;
          step_nxt  = step_r + 1'b1;
          case (kind_r)
            K_ADD: begin
              key_nxt[step_r[1:0]] = shifted;
              if (step_r == 3'd2) begin
                j_nxt     = '0;
                hit_nxt   = 1'b0;
                state_nxt = S_SR_RD;
              end
            end
            K_RK: begin
              if (!step_r[0]) begin
                cent_nxt = div_q[COORD_BITS-1:0];
              end else begin
                key_nxt[step_r[2:1]] = shifted;
              end
              if (step_r == 3'd5) begin
                j_nxt     = '0;
                hit_nxt   = 1'b0;
                state_nxt = S_SR_RD;
              end
            end
            default: begin
              case (step_r[1:0])
                2'd0:    out_nxt.mean_x = div_q[COORD_BITS-1:0];
                2'd1:    out_nxt.mean_y = div_q[COORD_BITS-1:0];
                2'd2:    out_nxt.mean_z = div_q[COORD_BITS-1:0];
                default: out_nxt.mean_intensity = div_q[INT_W-1:0];
              endcase
              if (step_r == 3'd3) begin
                fin       = 1'b1;
                fin_valid = 1'b1;
              end
            end
          endcase
        end
      end
      S_SR_RD: begin
        if (j_r == n_r) begin
          state_nxt = S_UPD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = j_r[AW-1:0];
          state_nxt = S_SR_CMP;
        end
      end
      S_SR_CMP: begin
        if (rd_data.key_x == key_r[0] && rd_data.key_y == key_r[1] &&
            rd_data.key_z == key_r[2]) begin
          hit_nxt   = 1'b1;
          state_nxt = S_UPD;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_SR_RD;
        end
      end
      S_UPD: begin
        if (hit_r) begin
          if (!cnt_sum[CNT_W]) begin
            wr_en   = 1'b1;
            wr_addr = j_r[AW-1:0];
            wr_data = merged;
          end
        end else if (32'(n_r) < 32'(TABLE_CELLS)) begin
          wr_en   = 1'b1;
          wr_addr = n_r[AW-1:0];
          n_nxt   = n_r + 1'b1;
        end
        if (kind_r == K_ADD) begin
          occ_nxt   = n_nxt;
          state_nxt = S_CHECK;
        end else if (src_r + 1'b1 == nold_r) begin
          occ_nxt   = n_nxt;
          state_nxt = S_CHECK;
        end else begin
          src_nxt   = src_r + 1'b1;
          state_nxt = S_RK_RD;
        end
      end
      S_CHECK: begin
        if (32'(occ_r) > lim32 && lvl_r != MAX_LEVEL) begin
          lvl_nxt   = lvl_r + 1'b1;
          nold_nxt  = occ_r;
          n_nxt     = '0;
          src_nxt   = '0;
          kind_nxt  = K_RK;
          state_nxt = S_RK_RD;
        end else begin
          fin = 1'b1;
        end
      end
      S_RK_RD: begin
        rd_en     = 1'b1;
        rd_addr   = src_r[AW-1:0];
        state_nxt = S_RK_LD;
      end
      S_RK_LD: begin
        cur_nxt   = rd_data;
        step_nxt  = '0;
        state_nxt = S_DIV_GO;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (fin) begin
      state_nxt          = S_IDLE;
      out_valid_nxt      = 1'b1;
      out_nxt.occupied   = OCC_W'(occ_nxt);
      out_nxt.level      = lvl_nxt;
      out_nxt.cell_valid = fin_valid;
      if (!fin_valid) begin
        out_nxt.mean_x         = '0;
        out_nxt.mean_y         = '0;
        out_nxt.mean_z         = '0;
        out_nxt.mean_intensity = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= BASE_VOXEL_RST;
      maxc_r      <= MAX_CELLS_RST;
      occ_r       <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      maxc_r      <= maxc_nxt;
      occ_r       <= occ_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r <= kind_nxt;
    step_r <= step_nxt;
    n_r    <= n_nxt;
    nold_r <= nold_nxt;
    src_r  <= src_nxt;
    j_r    <= j_nxt;
    hit_r  <= hit_nxt;
    cur_r  <= cur_nxt;
    key_r  <= key_nxt;
    cent_r <= cent_nxt;
    out_r  <= out_nxt;
  end

  avgd_div #(
    .DW(SUM_W),
    .NW(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  avgd_tbl #(
    .DEPTH(TABLE_CELLS)
  ) u_tbl (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(occ_r) <= 32'(TABLE_CELLS))
    else $error("occupied count beyond table size");

  a_result_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("item finished without result strobe");

  a_div_expected: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV_WT))
    else $error("divider done outside wait state");

endmodule

### tb/sv/adaptive_voxel_grid_downsampler_tb.sv
// ----------------------------------------------------------------------------
// adaptive_voxel_grid_downsampler_tb
// Self-checking testbench for the adaptive voxel grid downsampler. A queue of
// add, read, clear and unknown-op items feeds a clocked driver with random
// gaps; an in-bench voxel table model predicts every result, and a monitor
// compares each strobed result field by field. Several voxel edge and cell
// limit settings are visited, the extremes among them.
// ----------------------------------------------------------------------------
module adaptive_voxel_grid_downsampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import avgd_pkg::*;

  localparam int                TBL        = TABLE_CELLS_DEF;
  localparam logic [OP_W-1:0]   OP_NONE    = 2'd3;
  localparam int                IDLE_LIMIT = 2000000;
  localparam int                NUM_PHASES = 7;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  avgd_in_t              in_data = '0;
  logic                  out_valid;
  avgd_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adaptive_voxel_grid_downsampler uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // voxel table model
  bit              used_m [TBL];
  longint          kx_m [TBL], ky_m [TBL], kz_m [TBL];
  longint          sx_m [TBL], sy_m [TBL], sz_m [TBL];
  longint unsigned si_m [TBL], cnt_m [TBL];
  int unsigned     occ_m;
  int unsigned     lvl_m;
  int unsigned     base_m = 100;
  int unsigned     maxc_m = 4000;

  avgd_in_t  pend_q [$];
  avgd_out_t cell_result_q [$];
  avgd_out_t want;
  int        gap_left = 0;
  bit        gaps_on = 1'b1;
  int        mismatches = 0;
  int        idle_cycles = 0;

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint voxel_edge();
    longint b;
    b = (base_m == 0) ? 1 : base_m;
    return b << lvl_m;
  endfunction

  function automatic void rekey_cells();
    longint v, c, kx, ky, kz;
    int     n, j, hit;
    v = voxel_edge();
    n = 0;
    for (int i = 0; i < TBL; i++) begin
      if (used_m[i]) begin
        c = longint'(cnt_m[i]);
        kx = floor_div(floor_div(sx_m[i], c), v);
        ky = floor_div(floor_div(sy_m[i], c), v);
        kz = floor_div(floor_div(sz_m[i], c), v);
        hit = -1;
        for (j = 0; j < n; j++) begin
          if (kx_m[j] == kx && ky_m[j] == ky && kz_m[j] == kz) begin
            hit = j;
            break;
          end
        end
        if (hit >= 0) begin
          if (cnt_m[hit] + cnt_m[i] <= 64'hFFFF_FFFF) begin
            sx_m[hit] += sx_m[i];
            sy_m[hit] += sy_m[i];
            sz_m[hit] += sz_m[i];
            si_m[hit] += si_m[i];
            cnt_m[hit] += cnt_m[i];
          end
        end else begin
          kx_m[n] = kx; ky_m[n] = ky; kz_m[n] = kz;
          sx_m[n] = sx_m[i]; sy_m[n] = sy_m[i]; sz_m[n] = sz_m[i];
          si_m[n] = si_m[i]; cnt_m[n] = cnt_m[i];
          n++;
        end
      end
    end
    for (int i = 0; i < TBL; i++) used_m[i] = (i < n);
    occ_m = n;
  endfunction

  function automatic void add_point(longint x, longint y, longint z, longint unsigned it);
    longint      v, kx, ky, kz;
    int          target;
    bit          hit, have_free;
    int unsigned lim;
    v = voxel_edge();
    kx = floor_div(x, v); ky = floor_div(y, v); kz = floor_div(z, v);
    target = 0; hit = 0; have_free = 0;
    for (int i = 0; i < TBL; i++) begin
      if (used_m[i]) begin
        if (kx_m[i] == kx && ky_m[i] == ky && kz_m[i] == kz) begin
          target = i;
          hit = 1;
          break;
        end
      end else if (!have_free) begin
        have_free = 1;
        target = i;
      end
    end
    if (hit) begin
      if (cnt_m[target] < 64'hFFFF_FFFF) begin
        sx_m[target] += x; sy_m[target] += y; sz_m[target] += z;
        si_m[target] += it;
        cnt_m[target] += 1;
      end
    end else if (have_free) begin
      used_m[target] = 1;
      kx_m[target] = kx; ky_m[target] = ky; kz_m[target] = kz;
      sx_m[target] = x; sy_m[target] = y; sz_m[target] = z;
      si_m[target] = it; cnt_m[target] = 1;
      occ_m++;
    end
    lim = (maxc_m > TBL - 1) ? TBL - 1 : maxc_m;
    while (occ_m > lim && lvl_m < MAX_LEVEL) begin
      lvl_m++;
      rekey_cells();
    end
  endfunction

  function automatic avgd_out_t predict_voxel_op(avgd_in_t it);
    avgd_out_t r;
    longint    c;
    r = '0;
    case (it.op)
      OP_ADD: begin
        add_point(longint'(it.px), longint'(it.py), longint'(it.pz),
                  longint'(it.intensity));
      end
      OP_READ: begin
        if (it.slot < TBL && used_m[it.slot]) begin
          c = longint'(cnt_m[it.slot]);
          r.cell_valid = 1'b1;
          r.mean_x = COORD_BITS'(floor_div(sx_m[it.slot], c));
          r.mean_y = COORD_BITS'(floor_div(sy_m[it.slot], c));
          r.mean_z = COORD_BITS'(floor_div(sz_m[it.slot], c));
          r.mean_intensity = INT_W'(si_m[it.slot] / cnt_m[it.slot]);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < TBL; i++) used_m[i] = 0;
        occ_m = 0;
        lvl_m = 0;
      end
      default: ;
    endcase
    r.occupied = OCC_W'(occ_m);
    r.level = LVL_W'(lvl_m);
    return r;
  endfunction

  task automatic report_mismatch(string fld, longint got, longint exp_v);
    $display("%0t: %s got %0d want %0d", $realtime, fld, got, exp_v);
    mismatches++;
  endtask

  task automatic enqueue_item(avgd_in_t it);
    pend_q.insert(pend_q.size(), it);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        want = predict_voxel_op(in_data);
        cell_result_q.insert(cell_result_q.size(), want);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pend_q.size() > 0) begin
          in_data <= pend_q.pop_front();
          start <= 1'b1;
          gap_left <= gaps_on ? $urandom_range(0, 9) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    avgd_out_t e;
    if (rst_n && out_valid) begin
      if (cell_result_q.size() == 0) begin
        report_mismatch("unexpected result, occupied", out_data.occupied, 0);
      end else begin
        e = cell_result_q.pop_front();
        if (out_data.occupied !== e.occupied)
          report_mismatch("occupied", out_data.occupied, e.occupied);
        if (out_data.level !== e.level)
          report_mismatch("level", out_data.level, e.level);
        if (out_data.cell_valid !== e.cell_valid)
          report_mismatch("cell_valid", out_data.cell_valid, e.cell_valid);
        if (out_data.mean_x !== e.mean_x)
          report_mismatch("mean_x", out_data.mean_x, e.mean_x);
        if (out_data.mean_y !== e.mean_y)
          report_mismatch("mean_y", out_data.mean_y, e.mean_y);
        if (out_data.mean_z !== e.mean_z)
          report_mismatch("mean_z", out_data.mean_z, e.mean_z);
        if (out_data.mean_intensity !== e.mean_intensity)
          report_mismatch("mean_intensity", out_data.mean_intensity, e.mean_intensity);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic avgd_in_t make_item(logic [OP_W-1:0] op, longint x, longint y,
                                         longint z, int unsigned it, int unsigned sl);
    avgd_in_t r;
    r.op = op;
    r.px = COORD_BITS'(x); r.py = COORD_BITS'(y); r.pz = COORD_BITS'(z);
    r.intensity = INT_W'(it);
    r.slot = SLOT_W'(sl);
    return r;
  endfunction

  function automatic longint clip(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  task automatic drain();
    do @(posedge clk);
    while (pend_q.size() != 0 || cell_result_q.size() != 0 || start || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == CFG_BASE_VOXEL) base_m = val & 16'hFFFF;
    else maxc_m = val & 12'hFFF;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  int unsigned base_tab [NUM_PHASES] = '{1, 65535, 0, 37, 250, 5, 100};
  int unsigned maxc_tab [NUM_PHASES] = '{4095, 1, 3, 0, 6, 20, 4000};
  int          cnt_tab  [NUM_PHASES] = '{95, 95, 95, 12, 95, 95, 95};

  initial begin
    longint      cx, cy, cz, sp;
    int unsigned r;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    enqueue_item(make_item(OP_READ, 0, 0, 0, 0, 0));
    enqueue_item(make_item(OP_ADD, 8388607, 8388607, 8388607, 65535, 4095));
    enqueue_item(make_item(OP_ADD, -8388608, -8388608, -8388608, 0, 0));
    enqueue_item(make_item(OP_ADD, 0, 0, 0, 1, 0));
    enqueue_item(make_item(OP_ADD, 99, 50, 1, 65535, 0));
    enqueue_item(make_item(OP_ADD, -1, -1, -1, 7, 0));
    enqueue_item(make_item(OP_ADD, -100, -101, -99, 3, 0));
    enqueue_item(make_item(OP_ADD, -150, -199, -101, 4, 0));
    for (int s = 0; s < 7; s++) enqueue_item(make_item(OP_READ, 0, 0, 0, 0, s));
    enqueue_item(make_item(OP_READ, -1, -1, -1, 65535, 4095));
    enqueue_item(make_item(OP_NONE, 5, 5, 5, 5, 1));
    enqueue_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
    enqueue_item(make_item(OP_READ, 0, 0, 0, 0, 0));
    enqueue_item(make_item(OP_ADD, -8388608, 8388607, 0, 65535, 0));
    enqueue_item(make_item(OP_READ, 0, 0, 0, 0, 0));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_cfg(CFG_BASE_VOXEL, base_tab[p]);
      write_cfg(CFG_MAX_CELLS, maxc_tab[p]);
      gaps_on = (p % 3) != 0;
      enqueue_item(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
      cx = clip(longint'($signed($urandom)) >>> 9);
      cy = clip(longint'($signed($urandom)) >>> 9);
      cz = clip(longint'($signed($urandom)) >>> 9);
      case ($urandom_range(0, 2))
        0: sp = base_tab[p] / 2 + 1;
        1: sp = base_tab[p] * 4 + 1;
        default: sp = 1 << 20;
      endcase
      for (int k = 0; k < cnt_tab[p]; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          cx = clip(longint'($signed($urandom)) >>> 8);
          cy = clip(longint'($signed($urandom)) >>> 8);
          cz = clip(longint'($signed($urandom)) >>> 8);
        end
        if (r < 55) begin
          enqueue_item(make_item(OP_ADD,
            clip(cx + longint'($urandom_range(0, 2 * sp)) - sp),
            clip(cy + longint'($urandom_range(0, 2 * sp)) - sp),
            clip(cz + longint'($urandom_range(0, 2 * sp)) - sp),
            $urandom, $urandom));
        end else if (r < 65) begin
          enqueue_item(make_item(OP_ADD, longint'($signed($urandom)) >>> 8,
            longint'($signed($urandom)) >>> 8, longint'($signed($urandom)) >>> 8,
            $urandom, $urandom));
        end else if (r < 85) begin
          enqueue_item(make_item(OP_READ, $urandom, $urandom, $urandom,
                                 $urandom, $urandom_range(0, 20)));
        end else if (r < 88) begin
          enqueue_item(make_item(OP_READ, $urandom, $urandom, $urandom,
                                 $urandom, $urandom));
        end else if (r < 93) begin
          enqueue_item(make_item(OP_CLEAR, $urandom, $urandom, $urandom,
                                 $urandom, $urandom));
        end else begin
          enqueue_item(make_item(OP_NONE, $urandom, $urandom, $urandom,
                                 $urandom, $urandom));
        end
      end
      for (int s = 0; s < 4; s++)
        enqueue_item(make_item(OP_READ, 0, 0, 0, 0, s));
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
